/* hw/rtl/mbrm_pkg.sv */
// Shared types and constants for the Modbus slave register map.
// No dependencies; every other file of the block but the checker refers to this package by scoped names.
package mbrm_pkg;

	localparam int ALU_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_RESULTS = 64;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
	localparam int BYTE_BITS   = 8;
	localparam logic [7:0] BYTE_MASK = 8'hFF;

	// power-up coil pattern and fixed discrete pattern, cut to the table size
	localparam logic [31:0] COIL_RESET_PAT = 32'h0000_0200;
	localparam logic [31:0] DISC_PAT       = 32'h0000_0201;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_BASE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COIL_BASE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DISCRETE_BASE = 2'd3;

	typedef enum logic [2:0] {
		OP_RD_HOLD  = 3'd0,
		OP_WR_HOLD  = 3'd1,
		OP_RD_INPUT = 3'd2,
		OP_RD_COIL  = 3'd3,
		OP_WR_COIL  = 3'd4,
		OP_RD_DISC  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		TBL_HOLD,
		TBL_INPUT,
		TBL_COIL,
		TBL_DISC
	} tbl_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] y;
		logic             borrow;
	} alu_rsp_t;

	typedef struct packed {
		logic        hold_we;
		logic        coil_we;
		logic        coil_bit;
		logic [15:0] addr;
		logic [15:0] wdata;
	} store_wr_t;

	typedef struct packed {
		tbl_t        tbl;
		logic [15:0] addr;
	} store_rd_t;

endpackage

/* hw/rtl/mbrm_intf.sv */
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on mbrm_pkg for the configuration index width.
interface mbrm_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [15:0] start_addr;
	logic [15:0] item_count;
	logic [7:0]  element_index;
	logic [15:0] write_value;

	modport source (output valid, opcode, start_addr, item_count, element_index, write_value,
		input ready);
	modport sink (input valid, opcode, start_addr, item_count, element_index, write_value,
		output ready);
endinterface

interface mbrm_resp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       status;
	logic       last;

	modport source (output valid, data_byte, status, last, input ready);
	modport sink (input valid, data_byte, status, last, output ready);
endinterface

interface mbrm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mbrm_pkg::CFG_IDX_W-1:0] index;
	logic [15:0]                    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/mbrm_alu.sv */
// Shared 17-bit add/subtract unit used for range checks, offsets and remaining counts.
// Depends on mbrm_pkg (alu_req_t, alu_rsp_t).
module mbrm_alu (
	input  mbrm_pkg::alu_req_t op,
	output mbrm_pkg::alu_rsp_t res
);
	logic [mbrm_pkg::ALU_W:0] sum;

	always_comb begin
		if (op.sub) begin
			sum = {1'b0, op.a} - {1'b0, op.b};
		end else begin
			sum = {1'b0, op.a} + {1'b0, op.b};
		end
		res.y      = sum[mbrm_pkg::ALU_W-1:0];
		res.borrow = sum[mbrm_pkg::ALU_W];
	end
endmodule

/* hw/rtl/mbrm_store.sv */
// Register and bit tables: holding registers, coil bits, and the fixed input/discrete tables.
// Depends on mbrm_pkg (store_wr_t, store_rd_t, reset patterns).
module mbrm_store #(
	parameter int HOLDING_COUNT  = 32,
	parameter int INPUT_COUNT    = 8,
	parameter int COIL_COUNT     = 16,
	parameter int DISCRETE_COUNT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbrm_pkg::store_wr_t   wr,
	input  mbrm_pkg::store_rd_t   rd,
	output logic [15:0]           rd_word,
	output logic [7:0]            rd_bits
);
	localparam int HIDX_W = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
	localparam int CIDX_W = $clog2(COIL_COUNT);
	localparam logic [16:0] HOLD_SIZE  = 17'(HOLDING_COUNT);
	localparam logic [16:0] INPUT_SIZE = 17'(INPUT_COUNT);
	localparam logic [16:0] COIL_SIZE  = 17'(COIL_COUNT);
	localparam logic [COIL_COUNT-1:0] COIL_RST = COIL_COUNT'(mbrm_pkg::COIL_RESET_PAT);
	localparam logic [DISCRETE_COUNT-1:0] DISC_BITS = DISCRETE_COUNT'(mbrm_pkg::DISC_PAT);

	logic [15:0]           hold_q [HOLDING_COUNT];
	logic [COIL_COUNT-1:0] coil_q;

	logic [COIL_COUNT+7:0]     coil_win;
	logic [DISCRETE_COUNT+7:0] disc_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HOLDING_COUNT; i++) begin
				hold_q[i] <= '0;
			end
			coil_q <= COIL_RST;
		end else begin
			if (wr.hold_we && ({1'b0, wr.addr} < HOLD_SIZE)) begin
				hold_q[wr.addr[HIDX_W-1:0]] <= wr.wdata;
			end
			if (wr.coil_we && ({1'b0, wr.addr} < COIL_SIZE)) begin
				coil_q[wr.addr[CIDX_W-1:0]] <= wr.coil_bit;
			end
		end
	end

	// bits past the table end read as zero
	assign coil_win = {8'h00, coil_q} >> rd.addr;
	assign disc_win = {8'h00, DISC_BITS} >> rd.addr;

	always_comb begin
		case (rd.tbl)
			mbrm_pkg::TBL_HOLD: begin
				rd_word = ({1'b0, rd.addr} < HOLD_SIZE) ? hold_q[rd.addr[HIDX_W-1:0]] : 16'h0000;
				rd_bits = 8'h00;
			end
			mbrm_pkg::TBL_INPUT: begin
				// input register i holds i
				rd_word = ({1'b0, rd.addr} < INPUT_SIZE) ? rd.addr : 16'h0000;
				rd_bits = 8'h00;
			end
			mbrm_pkg::TBL_COIL: begin
				rd_word = 16'h0000;
				rd_bits = coil_win[7:0];
			end
			mbrm_pkg::TBL_DISC: begin
				rd_word = 16'h0000;
				rd_bits = disc_win[7:0];
			end
			default: begin
				rd_word = 16'h0000;
				rd_bits = 8'h00;
			end
		endcase
	end
endmodule

/* hw/rtl/mbrm_seq.sv */
// Request sequencer: range checks, write steps and response byte generation.
// Depends on mbrm_pkg and the channel interfaces; drives the shared ALU and the table store.
module mbrm_seq #(
	parameter int HOLDING_COUNT  = 32,
	parameter int INPUT_COUNT    = 8,
	parameter int COIL_COUNT     = 16,
	parameter int DISCRETE_COUNT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	mbrm_req_if.sink            req,
	mbrm_resp_if.source         resp,
	mbrm_cfg_if.sink            cfg,
	output mbrm_pkg::alu_req_t  alu_op,
	input  mbrm_pkg::alu_rsp_t  alu_res,
	output mbrm_pkg::store_wr_t wr,
	output mbrm_pkg::store_rd_t rd,
	input  logic [15:0]         rd_word,
	input  logic [7:0]          rd_bits
);
	localparam logic [16:0] HOLD_SIZE  = 17'(HOLDING_COUNT);
	localparam logic [16:0] INPUT_SIZE = 17'(INPUT_COUNT);
	localparam logic [16:0] COIL_SIZE  = 17'(COIL_COUNT);
	localparam logic [16:0] DISC_SIZE  = 17'(DISCRETE_COUNT);
	localparam logic [mbrm_pkg::RES_CNT_W-1:0] N_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BASE,
		S_END,
		S_LIM,
		S_ELEM,
		S_WIDX,
		S_CREM,
		S_CBIT,
		S_EMIT,
		S_ACK,
		S_ERR
	} state_t;

	state_t        state_q;
	mbrm_pkg::op_t op_q;
	logic [15:0]   start_q;
	logic [15:0]   count_q;
	logic [7:0]    elem_q;
	logic [15:0]   wval_q;
	logic [15:0]   off_q;
	logic [16:0]   tmp_q;   // end address, then remaining count
	logic [15:0]   pos_q;   // table offset of the next word / bit
	logic [2:0]    bit_q;
	logic          lo_q;
	logic [mbrm_pkg::RES_CNT_W-1:0] n_q;

	logic        resp_vld_q;
	logic [7:0]  data_q;
	logic        status_q;
	logic        last_q;

	logic [15:0] holding_base_q;
	logic [15:0] input_base_q;
	logic [15:0] coil_base_q;
	logic [15:0] discrete_base_q;

	mbrm_pkg::tbl_t tbl;
	logic [15:0] base_sel;
	logic [16:0] size_sel;
	logic        is_word;
	logic        is_write;
	logic [16:0] elem_ext;
	logic [16:0] elem8;
	logic [16:0] elem_step;
	logic [3:0]  take;
	logic [7:0]  take_mask;
	logic        slot_free;
	logic        resp_load;
	logic [7:0]  emit_byte;
	logic        emit_last;
	logic        rem_done;

	always_comb begin
		case (op_q)
			mbrm_pkg::OP_RD_HOLD, mbrm_pkg::OP_WR_HOLD: begin
				tbl = mbrm_pkg::TBL_HOLD;
				base_sel = holding_base_q;
				size_sel = HOLD_SIZE;
			end
			mbrm_pkg::OP_RD_INPUT: begin
				tbl = mbrm_pkg::TBL_INPUT;
				base_sel = input_base_q;
				size_sel = INPUT_SIZE;
			end
			mbrm_pkg::OP_RD_COIL, mbrm_pkg::OP_WR_COIL: begin
				tbl = mbrm_pkg::TBL_COIL;
				base_sel = coil_base_q;
				size_sel = COIL_SIZE;
			end
			mbrm_pkg::OP_RD_DISC: begin
				tbl = mbrm_pkg::TBL_DISC;
				base_sel = discrete_base_q;
				size_sel = DISC_SIZE;
			end
			default: begin
				tbl = mbrm_pkg::TBL_HOLD;
				base_sel = 16'h0000;
				size_sel = 17'h00000;
			end
		endcase
	end

	assign is_word   = (tbl == mbrm_pkg::TBL_HOLD) || (tbl == mbrm_pkg::TBL_INPUT);
	assign is_write  = (op_q == mbrm_pkg::OP_WR_HOLD) || (op_q == mbrm_pkg::OP_WR_COIL);
	assign elem_ext  = {9'b0, elem_q};
	assign elem8     = {6'b0, elem_q, 3'b000};
	assign elem_step = (op_q == mbrm_pkg::OP_WR_HOLD) ? elem_ext : elem8;
	assign take      = (tmp_q >= 17'd8) ? 4'd8 : tmp_q[3:0];
	assign take_mask = ~(mbrm_pkg::BYTE_MASK << take);
	assign slot_free = !resp_vld_q || resp.ready;
	assign resp_load = slot_free
		&& ((state_q == S_EMIT) || (state_q == S_ACK) || (state_q == S_ERR));

	// shared ALU operand selection, at most one operation per state
	always_comb begin
		alu_op.a   = '0;
		alu_op.b   = '0;
		alu_op.sub = 1'b0;
		case (state_q)
			S_BASE: begin
				alu_op.a   = {1'b0, start_q};
				alu_op.b   = {1'b0, base_sel};
				alu_op.sub = 1'b1;
			end
			S_END: begin
				alu_op.a = {1'b0, off_q};
				alu_op.b = {1'b0, count_q};
			end
			S_LIM: begin
				alu_op.a   = size_sel;
				alu_op.b   = tmp_q;
				alu_op.sub = 1'b1;
			end
			S_ELEM: begin
				alu_op.a   = elem_step;
				alu_op.b   = {1'b0, count_q};
				alu_op.sub = 1'b1;
			end
			S_WIDX: begin
				alu_op.a = {1'b0, off_q};
				alu_op.b = elem_step;
			end
			S_CREM: begin
				alu_op.a   = {1'b0, count_q};
				alu_op.b   = elem8;
				alu_op.sub = 1'b1;
			end
			S_EMIT: begin
				alu_op.a   = tmp_q;
				alu_op.b   = is_word ? 17'd1 : {13'b0, take};
				alu_op.sub = 1'b1;
			end
			default: begin
				alu_op.a   = '0;
				alu_op.b   = '0;
				alu_op.sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr.hold_we  = (state_q == S_WIDX) && (op_q == mbrm_pkg::OP_WR_HOLD)
			&& (alu_res.y < HOLD_SIZE);
		wr.coil_we  = (state_q == S_CBIT) && (tmp_q > {14'b0, bit_q});
		wr.coil_bit = wval_q[bit_q];
		wr.addr     = (state_q == S_CBIT) ? pos_q : alu_res.y[15:0];
		wr.wdata    = wval_q;
		rd.tbl      = tbl;
		rd.addr     = pos_q;
	end

	assign rem_done = (alu_res.y == 17'h00000) || (n_q == N_MAX);

	always_comb begin
		if (is_word) begin
			emit_byte = lo_q ? rd_word[7:0] : rd_word[15:8];
			emit_last = lo_q && rem_done;
		end else begin
			emit_byte = rd_bits & take_mask;
			emit_last = rem_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_base_q  <= '0;
			input_base_q    <= '0;
			coil_base_q     <= '0;
			discrete_base_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				mbrm_pkg::CFG_HOLDING_BASE:  holding_base_q  <= cfg.data;
				mbrm_pkg::CFG_INPUT_BASE:    input_base_q    <= cfg.data;
				mbrm_pkg::CFG_COIL_BASE:     coil_base_q     <= cfg.data;
				mbrm_pkg::CFG_DISCRETE_BASE: discrete_base_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= mbrm_pkg::OP_RD_HOLD;
			start_q    <= '0;
			count_q    <= '0;
			elem_q     <= '0;
			wval_q     <= '0;
			off_q      <= '0;
			tmp_q      <= '0;
			pos_q      <= '0;
			bit_q      <= '0;
			lo_q       <= 1'b0;
			n_q        <= '0;
			resp_vld_q <= 1'b0;
			data_q     <= '0;
			status_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (resp_load) begin
				resp_vld_q <= 1'b1;
			end else if (resp.ready) begin
				resp_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= mbrm_pkg::op_t'(req.opcode);
						start_q <= req.start_addr;
						count_q <= req.item_count;
						elem_q  <= req.element_index;
						wval_q  <= req.write_value;
						case (mbrm_pkg::op_t'(req.opcode))
							mbrm_pkg::OP_RD_HOLD, mbrm_pkg::OP_WR_HOLD, mbrm_pkg::OP_RD_INPUT,
							mbrm_pkg::OP_RD_COIL, mbrm_pkg::OP_WR_COIL,
							mbrm_pkg::OP_RD_DISC: state_q <= S_BASE;
							default: state_q <= S_ERR;
						endcase
					end
				end
				S_BASE: begin
					if (alu_res.borrow) begin
						state_q <= S_ERR;
					end else begin
						off_q   <= alu_res.y[15:0];
						state_q <= S_END;
					end
				end
				S_END: begin
					tmp_q   <= alu_res.y;
					state_q <= S_LIM;
				end
				S_LIM: begin
					if (alu_res.borrow) begin
						state_q <= S_ERR;
					end else if (is_write) begin
						state_q <= S_ELEM;
					end else if (count_q == 16'h0000) begin
						state_q <= S_ACK;
					end else begin
						tmp_q   <= {1'b0, count_q};
						pos_q   <= off_q;
						lo_q    <= 1'b0;
						n_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_ELEM: begin
					// element must lie inside the request
					state_q <= alu_res.borrow ? S_WIDX : S_ERR;
				end
				S_WIDX: begin
					if (op_q == mbrm_pkg::OP_WR_HOLD) begin
						state_q <= (alu_res.y < HOLD_SIZE) ? S_ACK : S_ERR;
					end else begin
						pos_q   <= alu_res.y[15:0];
						state_q <= S_CREM;
					end
				end
				S_CREM: begin
					tmp_q   <= alu_res.y;
					bit_q   <= '0;
					state_q <= S_CBIT;
				end
				S_CBIT: begin
					pos_q <= pos_q + 16'd1;
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						state_q <= S_ACK;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						data_q     <= emit_byte;
						status_q   <= 1'b0;
						last_q     <= emit_last;
						n_q        <= n_q + mbrm_pkg::RES_CNT_W'(1);
						if (is_word) begin
							if (!lo_q) begin
								lo_q <= 1'b1;
							end else begin
								lo_q  <= 1'b0;
								tmp_q <= alu_res.y;
								pos_q <= pos_q + 16'd1;
							end
						end else begin
							tmp_q <= alu_res.y;
							pos_q <= pos_q + 16'(mbrm_pkg::BYTE_BITS);
						end
						if (emit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ACK: begin
					if (slot_free) begin
						data_q     <= 8'h00;
						status_q   <= 1'b0;
						last_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_ERR: begin
					if (slot_free) begin
						data_q     <= 8'h00;
						status_q   <= 1'b1;
						last_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign resp.valid     = resp_vld_q;
	assign resp.data_byte = data_q;
	assign resp.status    = status_q;
	assign resp.last      = last_q;
endmodule

/* hw/rtl/modbus_slave_register_map_unit.sv */
// Top level of the Modbus slave register map: sequencer, shared ALU and table store.
// Depends on mbrm_pkg, the channel interfaces, mbrm_alu, mbrm_store and mbrm_seq.
//
// Usage:
//   req  - requests: opcode, start address, item count, element index, write value.
//   resp - response bytes; last marks the final byte of a request. Errors and writes
//          give one byte of zero, status 1 on a range error or unused opcode.
//   cfg  - base address writes, index 0..3, always ready; write only while idle.
// Operation: a request is accepted only in the idle state. The range check uses the
//   shared adder in three steps (start - base, offset + count, size - end). Reads then
//   stream one byte per cycle while the receiver is ready (2 per register, 1 per 8
//   bits, at most 64). A write adds an element check and an index step; a coil write
//   then writes one coil bit per cycle over eight steps. Both end with the status byte.
// A response register separates the sides: a new request is taken while the last
//   byte of the previous one still waits. A stalled receiver holds the byte and
//   pauses the sequencer. Reset clears bases to 0, holding registers to 0, coils to
//   bit 9 only; input and discrete tables are fixed.
module modbus_slave_register_map_unit #(
	parameter int HOLDING_COUNT  = 32,
	parameter int INPUT_COUNT    = 8,
	parameter int COIL_COUNT     = 16,
	parameter int DISCRETE_COUNT = 16
) (
	input logic          clk,
	input logic          arst_n,
	mbrm_req_if.sink     req,
	mbrm_resp_if.source  resp,
	mbrm_cfg_if.sink     cfg
);
	mbrm_pkg::alu_req_t  alu_op;
	mbrm_pkg::alu_rsp_t  alu_res;
	mbrm_pkg::store_wr_t wr;
	mbrm_pkg::store_rd_t rd;
	logic [15:0]         rd_word;
	logic [7:0]          rd_bits;

	mbrm_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	mbrm_store #(
		.HOLDING_COUNT  (HOLDING_COUNT),
		.INPUT_COUNT    (INPUT_COUNT),
		.COIL_COUNT     (COIL_COUNT),
		.DISCRETE_COUNT (DISCRETE_COUNT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_word (rd_word),
		.rd_bits (rd_bits)
	);

	mbrm_seq #(
		.HOLDING_COUNT  (HOLDING_COUNT),
		.INPUT_COUNT    (INPUT_COUNT),
		.COIL_COUNT     (COIL_COUNT),
		.DISCRETE_COUNT (DISCRETE_COUNT)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.resp    (resp),
		.cfg     (cfg),
		.alu_op  (alu_op),
		.alu_res (alu_res),
		.wr      (wr),
		.rd      (rd),
		.rd_word (rd_word),
		.rd_bits (rd_bits)
	);
endmodule

/* hw/rtl/mbrm_checker.sv */
// Port-level checks for the register map, bound to the top level.
// Depends only on the top level's channel signals.
module mbrm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       resp_valid,
	input logic       resp_ready,
	input logic [7:0] resp_data_byte,
	input logic       resp_status,
	input logic       resp_last
);
	// one request at a time: the sequencer leaves idle right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request port ready right after a request");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && resp_status |-> resp_data_byte == 8'h00)
		else $error("error response carries data");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && resp_status |-> resp_last)
		else $error("error response not marked last");

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> resp_valid)
		else $error("response dropped while stalled");

	a_resp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=>
		$stable(resp_data_byte) && $stable(resp_status) && $stable(resp_last))
		else $error("response changed while stalled");
endmodule

bind modbus_slave_register_map_unit mbrm_checker u_mbrm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.resp_valid     (resp.valid),
	.resp_ready     (resp.ready),
	.resp_data_byte (resp.data_byte),
	.resp_status    (resp.status),
	.resp_last      (resp.last)
);

/* tb/sv/modbus_slave_register_map_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for modbus_slave_register_map_unit: table reads and writes, range errors.
// Depends on mbrm_pkg and the channel interfaces; keeps its own shadow of bases and tables.
module modbus_slave_register_map_unit_tb;

	localparam int HOLDING_COUNT  = 32;
	localparam int INPUT_COUNT    = 8;
	localparam int COIL_COUNT     = 16;
	localparam int DISCRETE_COUNT = 16;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int PRINT_CAP      = 200;

	localparam logic [15:0] COIL_POWERUP     = 16'h0200;
	localparam logic [15:0] DISCRETE_PATTERN = 16'h0201;
	localparam logic [2:0]  OP_UNUSED_6      = 3'd6;
	localparam logic [2:0]  OP_UNUSED_7      = 3'd7;

	typedef struct {
		logic [2:0]  opcode;
		logic [15:0] start_addr;
		logic [15:0] item_count;
		logic [7:0]  element_index;
		logic [15:0] write_value;
	} map_request_t;

	typedef struct {
		logic [7:0] data_byte;
		logic       status;
		logic       last;
	} map_byte_t;

	logic clk;
	logic arst_n;

	mbrm_req_if  req_ch ();
	mbrm_resp_if resp_ch ();
	mbrm_cfg_if  cfg_ch ();

	modbus_slave_register_map_unit #(
		.HOLDING_COUNT  (HOLDING_COUNT),
		.INPUT_COUNT    (INPUT_COUNT),
		.COIL_COUNT     (COIL_COUNT),
		.DISCRETE_COUNT (DISCRETE_COUNT)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.resp   (resp_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the block's state
	logic [15:0] base_shadow [4];
	logic [15:0] hold_shadow [HOLDING_COUNT];
	logic [15:0] coil_shadow;

	map_byte_t expected_bytes [$];
	map_byte_t staged [$];
	int        mismatches;
	int        cycles;
	int        send_idle_pct;
	int        stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		resp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		map_byte_t want;
		if (arst_n && resp_ch.valid && resp_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h status %0b last %0b",
					resp_ch.data_byte, resp_ch.status, resp_ch.last));
			end else begin
				want = expected_bytes.pop_front();
				if (resp_ch.data_byte !== want.data_byte)
					report_mismatch($sformatf("data_byte %02h, want %02h",
						resp_ch.data_byte, want.data_byte));
				if (resp_ch.status !== want.status)
					report_mismatch($sformatf("status %0b, want %0b",
						resp_ch.status, want.status));
				if (resp_ch.last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", resp_ch.last, want.last));
			end
		end
	end

	function automatic void reset_shadow();
		int i;
		for (i = 0; i < 4; i++)
			base_shadow[i] = '0;
		for (i = 0; i < HOLDING_COUNT; i++)
			hold_shadow[i] = '0;
		coil_shadow = COIL_POWERUP;
	endfunction

	function automatic bit fits(input int s, input int c, input int base, input int size);
		return s >= base && s + c <= base + size;
	endfunction

	function automatic void stage_byte(input logic [7:0] b, input logic st);
		map_byte_t r;
		r.data_byte = b;
		r.status    = st;
		r.last      = 1'b0;
		staged.push_back(r);
	endfunction

	function automatic void stage_word(input logic [15:0] w);
		stage_byte(w[15:8], 1'b0);
		stage_byte(w[7:0], 1'b0);
	endfunction

	// packed LSB first; a short last byte keeps its upper bits clear
	function automatic void stage_bits(input logic [15:0] bits, input int nbits,
		input int off, input int count);
		int rem, take, pos, b;
		logic [7:0] acc;
		rem = count;
		pos = off;
		while (rem > 0 && staged.size() < mbrm_pkg::MAX_RESULTS) begin
			take = (rem > mbrm_pkg::BYTE_BITS) ? mbrm_pkg::BYTE_BITS : rem;
			acc = '0;
			for (b = 0; b < take; b++)
				if (pos + b < nbits)
					acc[b] = bits[pos + b];
			stage_byte(acc, 1'b0);
			rem -= take;
			pos += mbrm_pkg::BYTE_BITS;
		end
	endfunction

	function automatic void predict_map_response(input map_request_t rq);
		int s, c, e, off, i, first, take;
		bit ok;
		s  = rq.start_addr;
		c  = rq.item_count;
		e  = rq.element_index;
		ok = 1'b1;
		staged.delete();
		case (rq.opcode)
			mbrm_pkg::OP_RD_HOLD: begin
				if (fits(s, c, base_shadow[mbrm_pkg::CFG_HOLDING_BASE], HOLDING_COUNT)) begin
					off = s - int'(base_shadow[mbrm_pkg::CFG_HOLDING_BASE]);
					for (i = 0; i < c && staged.size() + 2 <= mbrm_pkg::MAX_RESULTS; i++)
						stage_word(hold_shadow[off + i]);
				end else
					ok = 1'b0;
			end
			mbrm_pkg::OP_WR_HOLD: begin
				off = s - int'(base_shadow[mbrm_pkg::CFG_HOLDING_BASE]);
				if (fits(s, c, base_shadow[mbrm_pkg::CFG_HOLDING_BASE], HOLDING_COUNT)
					&& e < c && off + e < HOLDING_COUNT) begin
					hold_shadow[off + e] = rq.write_value;
					stage_byte('0, 1'b0);
				end else
					ok = 1'b0;
			end
			mbrm_pkg::OP_RD_INPUT: begin
				if (fits(s, c, base_shadow[mbrm_pkg::CFG_INPUT_BASE], INPUT_COUNT)) begin
					off = s - int'(base_shadow[mbrm_pkg::CFG_INPUT_BASE]);
					for (i = 0; i < c && staged.size() + 2 <= mbrm_pkg::MAX_RESULTS; i++)
						stage_word(16'(off + i));
				end else
					ok = 1'b0;
			end
			mbrm_pkg::OP_RD_COIL: begin
				if (fits(s, c, base_shadow[mbrm_pkg::CFG_COIL_BASE], COIL_COUNT))
					stage_bits(coil_shadow, COIL_COUNT,
						s - int'(base_shadow[mbrm_pkg::CFG_COIL_BASE]), c);
				else
					ok = 1'b0;
			end
			mbrm_pkg::OP_WR_COIL: begin
				if (fits(s, c, base_shadow[mbrm_pkg::CFG_COIL_BASE], COIL_COUNT)
					&& e * mbrm_pkg::BYTE_BITS < c) begin
					first = s - int'(base_shadow[mbrm_pkg::CFG_COIL_BASE])
						+ e * mbrm_pkg::BYTE_BITS;
					take  = c - e * mbrm_pkg::BYTE_BITS;
					if (take > mbrm_pkg::BYTE_BITS)
						take = mbrm_pkg::BYTE_BITS;
					for (i = 0; i < take; i++)
						if (first + i < COIL_COUNT)
							coil_shadow[first + i] = rq.write_value[i];
					stage_byte('0, 1'b0);
				end else
					ok = 1'b0;
			end
			mbrm_pkg::OP_RD_DISC: begin
				if (fits(s, c, base_shadow[mbrm_pkg::CFG_DISCRETE_BASE], DISCRETE_COUNT))
					stage_bits(DISCRETE_PATTERN, DISCRETE_COUNT,
						s - int'(base_shadow[mbrm_pkg::CFG_DISCRETE_BASE]), c);
				else
					ok = 1'b0;
			end
			default: ok = 1'b0;
		endcase
		if (!ok) begin
			staged.delete();
			stage_byte('0, 1'b1);
		end else if (staged.size() == 0)
			stage_byte('0, 1'b0);
		staged[staged.size() - 1].last = 1'b1;
		foreach (staged[k])
			expected_bytes.push_back(staged[k]);
	endfunction

	function automatic map_request_t mk(input logic [2:0] op, input logic [15:0] s,
		input logic [15:0] c, input logic [7:0] e, input logic [15:0] v);
		map_request_t rq;
		rq.opcode        = op;
		rq.start_addr    = s;
		rq.item_count    = c;
		rq.element_index = e;
		rq.write_value   = v;
		return rq;
	endfunction

	// valid is left high after acceptance; the next call or drop_request settles it
	task automatic send_request(input map_request_t rq);
		@(negedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.opcode        <= rq.opcode;
		req_ch.start_addr    <= rq.start_addr;
		req_ch.item_count    <= rq.item_count;
		req_ch.element_index <= rq.element_index;
		req_ch.write_value   <= rq.write_value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predict_map_response(rq);
	endtask

	task automatic drop_request();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_bases(input logic [15:0] hold_b, input logic [15:0] in_b,
		input logic [15:0] coil_b, input logic [15:0] disc_b);
		logic [15:0]                    vals [4];
		logic [mbrm_pkg::CFG_IDX_W-1:0] regs [4];
		int k;
		vals[0] = hold_b;
		vals[1] = in_b;
		vals[2] = coil_b;
		vals[3] = disc_b;
		regs[0] = mbrm_pkg::CFG_HOLDING_BASE;
		regs[1] = mbrm_pkg::CFG_INPUT_BASE;
		regs[2] = mbrm_pkg::CFG_COIL_BASE;
		regs[3] = mbrm_pkg::CFG_DISCRETE_BASE;
		wait_drained();
		for (k = 0; k < 4; k++) begin
			@(negedge clk);
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[k];
			cfg_ch.data  <= vals[k];
			@(posedge clk);
			while (!cfg_ch.ready)
				@(posedge clk);
			base_shadow[regs[k]] = vals[k];
		end
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly requests that pass the range check, with some broken ones and raw noise
	task automatic build_request(output map_request_t rq);
		int base, size, hi, s, c, e, roll;
		roll             = $urandom_range(99, 0);
		rq.opcode        = 3'($urandom_range(5, 0));
		rq.element_index = 8'($urandom);
		rq.write_value   = 16'($urandom);
		if (roll < 12) begin
			rq.opcode     = 3'($urandom_range(7, 0));
			rq.start_addr = 16'($urandom);
			rq.item_count = 16'($urandom);
			return;
		end
		case (rq.opcode)
			mbrm_pkg::OP_RD_HOLD, mbrm_pkg::OP_WR_HOLD: begin
				base = base_shadow[mbrm_pkg::CFG_HOLDING_BASE];
				size = HOLDING_COUNT;
			end
			mbrm_pkg::OP_RD_INPUT: begin
				base = base_shadow[mbrm_pkg::CFG_INPUT_BASE];
				size = INPUT_COUNT;
			end
			mbrm_pkg::OP_RD_COIL, mbrm_pkg::OP_WR_COIL: begin
				base = base_shadow[mbrm_pkg::CFG_COIL_BASE];
				size = COIL_COUNT;
			end
			default: begin
				base = base_shadow[mbrm_pkg::CFG_DISCRETE_BASE];
				size = DISCRETE_COUNT;
			end
		endcase
		hi = base + size - 1;
		if (hi > 16'hFFFF)
			hi = 16'hFFFF;
		s = $urandom_range(hi, base);
		c = $urandom_range(base + size - s, 0);
		e = rq.element_index;
		if (rq.opcode == mbrm_pkg::OP_WR_HOLD || rq.opcode == mbrm_pkg::OP_WR_COIL) begin
			if (c == 0)
				c = 1;
			if (rq.opcode == mbrm_pkg::OP_WR_HOLD)
				e = $urandom_range(c - 1, 0);
			else
				e = $urandom_range((c - 1) / mbrm_pkg::BYTE_BITS, 0);
		end
		if (roll < 24) begin
			case ($urandom_range(2, 0))
				0: if (s > 0) s = s - 1; else c = c + 1;
				1: c = c + 1;
				default: e = (rq.opcode == mbrm_pkg::OP_WR_COIL)
					? (c + 7) / mbrm_pkg::BYTE_BITS : c;
			endcase
		end
		rq.start_addr    = 16'(s);
		rq.item_count    = 16'(c);
		rq.element_index = 8'(e);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_request(mk(mbrm_pkg::OP_RD_HOLD, 16'd0, 16'd32, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_INPUT, 16'd0, 16'd8, 8'hFF, 16'hFFFF));
		send_request(mk(mbrm_pkg::OP_RD_COIL, 16'd0, 16'd16, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_DISC, 16'd0, 16'd16, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_DISC, 16'd0, 16'd10, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_COIL, 16'd7, 16'd5, 8'd0, 16'd0));
		// zero-count reads answer one ok byte
		send_request(mk(mbrm_pkg::OP_RD_HOLD, 16'd0, 16'd0, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_DISC, 16'd16, 16'd0, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_WR_HOLD, 16'd0, 16'd32, 8'd31, 16'hFFFF));
		send_request(mk(mbrm_pkg::OP_WR_HOLD, 16'd5, 16'd2, 8'd1, 16'hA5A5));
		send_request(mk(mbrm_pkg::OP_WR_HOLD, 16'd0, 16'd2, 8'd2, 16'h1234));
		send_request(mk(mbrm_pkg::OP_WR_COIL, 16'd3, 16'd11, 8'd1, 16'hFFFF));
		send_request(mk(mbrm_pkg::OP_WR_COIL, 16'd3, 16'd11, 8'd0, 16'h55AA));
		send_request(mk(mbrm_pkg::OP_WR_COIL, 16'd0, 16'd8, 8'd1, 16'h00FF));
		send_request(mk(mbrm_pkg::OP_RD_HOLD, 16'd0, 16'd33, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_INPUT, 16'hFFFF, 16'hFFFF, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_COIL, 16'd1, 16'd16, 8'd0, 16'd0));
		send_request(mk(OP_UNUSED_6, 16'd0, 16'd1, 8'd0, 16'd0));
		send_request(mk(OP_UNUSED_7, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
		send_request(mk(mbrm_pkg::OP_RD_COIL, 16'd0, 16'd16, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_HOLD, 16'd0, 16'd32, 8'd0, 16'd0));
		drop_request();
	endtask

	// pause_at >= 0 holds the sender until every pending response is back
	task automatic test_random_phase(input int idle_pct, input int stall, input int n_items,
		input int pause_at);
		map_request_t rq;
		int i;
		send_idle_pct = idle_pct;
		stall_pct     = stall;
		for (i = 0; i < n_items; i++) begin
			if (i == pause_at) begin
				drop_request();
				wait_drained();
			end
			build_request(rq);
			send_request(rq);
		end
		drop_request();
	endtask

	task automatic test_top_of_space();
		write_bases(16'hFFE0, 16'hFFF8, 16'hFFF0, 16'hFFF0);
		send_request(mk(mbrm_pkg::OP_WR_HOLD, 16'hFFFF, 16'd1, 8'd0, 16'hBEEF));
		send_request(mk(mbrm_pkg::OP_RD_HOLD, 16'hFFE0, 16'd32, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_INPUT, 16'hFFF8, 16'd8, 8'd0, 16'd0));
		send_request(mk(mbrm_pkg::OP_RD_HOLD, 16'hFFDF, 16'd1, 8'd0, 16'd0));
		drop_request();
		test_random_phase(34, 34, 100, 50);
	endtask

	initial begin
		arst_n               = 1'b0;
		req_ch.valid         = 1'b0;
		req_ch.opcode        = '0;
		req_ch.start_addr    = '0;
		req_ch.item_count    = '0;
		req_ch.element_index = '0;
		req_ch.write_value   = '0;
		resp_ch.ready        = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		mismatches           = 0;
		cycles               = 0;
		reset_shadow();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_bases(16'd0, 16'd0, 16'd0, 16'd0);
		test_random_phase(0, 0, 100, -1);
		write_bases(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		test_random_phase(80, 0, 100, -1);
		write_bases(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		test_random_phase(0, 80, 100, -1);
		test_top_of_space();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d response bytes never arrived", expected_bytes.size()));
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
